### hw/rtl/jbc_pkg.sv
// Package for the jitter buffer controller: codes, config record, defaults.
package jbc_pkg;

  localparam int MAX_SLOTS_DEF  = 16;
  localparam int SUB_BLOCKS_DEF = 2;

  localparam logic [4:0]  SLOT_COUNT_RST   = 5'd7;
  localparam logic [4:0]  PREFILL_RST      = 5'd3;
  localparam logic [15:0] PERIOD_RST       = 16'd2902;
  localparam logic [15:0] TIMEOUT_RST      = 16'd1000;

  // reciprocals of 3 for 16-bit and 18-bit dividends
  localparam logic [32:0] RECIP3_16 = 33'd43691;
  localparam int          SHIFT3_16 = 17;
  localparam logic [35:0] RECIP3_18 = 36'd174763;
  localparam int          SHIFT3_18 = 19;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT = 2'd0,
    REG_PREFILL    = 2'd1,
    REG_PERIOD     = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOPPED    = 2'd0,
    MODE_SYNCING    = 2'd1,
    MODE_PLAYING    = 2'd2,
    MODE_RECOVERING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_STORE   = 3'd0,
    ACT_FILLER  = 3'd1,
    ACT_PLAY    = 3'd2,
    ACT_SILENCE = 3'd3,
    ACT_LATE    = 3'd4,
    ACT_EARLY   = 3'd5,
    ACT_IGNORED = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_RDA,
    ST_RDB,
    ST_CALC,
    ST_PLAN,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic [4:0]  slot_count;
    logic [4:0]  prefill_level;
    logic [15:0] period_us;
    logic [15:0] timeout_ms;
    logic [15:0] gap_lo;
    logic [16:0] gap_hi;
  } cfg_t;

endpackage

### hw/rtl/jbc_cfg.sv
// APB register bank with the derived arrival gap window.
module jbc_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output jbc_pkg::cfg_t cfg
);
  import jbc_pkg::*;

  logic [4:0]  slot_count;
  logic [4:0]  prefill_level;
  logic [15:0] period_us;
  logic [15:0] timeout_ms;
  logic [15:0] gap_lo;
  logic [16:0] gap_hi;
  logic [32:0] prod_lo;
  logic [35:0] prod_hi;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= SLOT_COUNT_RST;
      prefill_level <= PREFILL_RST;
      period_us     <= PERIOD_RST;
      timeout_ms    <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SLOT_COUNT: slot_count    <= pwdata[4:0];
        REG_PREFILL:    prefill_level <= pwdata[4:0];
        REG_PERIOD:     period_us     <= pwdata[15:0];
        REG_TIMEOUT:    timeout_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLOT_COUNT: prdata = {27'd0, slot_count};
      REG_PREFILL:    prdata = {27'd0, prefill_level};
      REG_PERIOD:     prdata = {16'd0, period_us};
      REG_TIMEOUT:    prdata = {16'd0, timeout_ms};
      default:        prdata = 32'd0;
    endcase
  end

  assign prod_lo = 33'(period_us) * RECIP3_16;
  assign prod_hi = 36'({period_us, 2'b00}) * RECIP3_18;

  always_ff @(posedge clk) begin
    gap_lo <= 16'(prod_lo >> SHIFT3_16);
    gap_hi <= 17'(prod_hi >> SHIFT3_18);
  end

  always_comb begin
    cfg.slot_count    = slot_count;
    cfg.prefill_level = prefill_level;
    cfg.period_us     = period_us;
    cfg.timeout_ms    = timeout_ms;
    cfg.gap_lo        = gap_lo;
    cfg.gap_hi        = gap_hi;
  end

endmodule

### hw/rtl/jbc_slot_mem.sv
// Slot memory: seqno and arrival time per slot, registered read.
module jbc_slot_mem #(
  parameter int DEPTH = jbc_pkg::MAX_SLOTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rseq,
  output logic [31:0]   rarr,
  input  logic          we_seq,
  input  logic          we_arr,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wseq,
  input  logic [31:0]   warr
);
  logic [31:0]      seq_mem [DEPTH];
  logic [31:0]      arr_mem [DEPTH];
  logic [DEPTH-1:0] seq_vld;
  logic [DEPTH-1:0] arr_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_vld <= '0;
      arr_vld <= '0;
    end else begin
      if (we_seq) seq_vld[waddr] <= 1'b1;
      if (we_arr) arr_vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_seq) seq_mem[waddr] <= wseq;
    if (we_arr) arr_mem[waddr] <= warr;
    rseq <= seq_vld[raddr] ? seq_mem[raddr] : 32'd0;
    rarr <= arr_vld[raddr] ? arr_mem[raddr] : 32'd0;
  end

endmodule

### hw/rtl/audio_jitter_buffer_controller.sv
// Top level: jitter buffer slot sequencer with config bank and slot memory.
//
//  channel  | handshake                     | beat
//  ---------+-------------------------------+---------------------------------
//  command  | start && !busy                | cmd, seqno, now_us, now_ms
//  result   | done (one cycle, no stall)    | action .. recover_fail_total, last
//  config   | psel && penable && pwrite     | paddr, pwdata (pready tied high)
//
//  An item passes through k pointer reductions after a slot count change (one
//  subtract per cycle), two slot memory reads on the single read port, a
//  compare and a plan step, then one result per cycle for f fillers and the
//  final result. busy stays high until the last beat is issued. Reset clears
//  control state and the slot valid bits at once.
//  Results cannot be stalled.
module audio_jitter_buffer_controller #(
  parameter int MAX_SLOTS  = jbc_pkg::MAX_SLOTS_DEF,
  parameter int SUB_BLOCKS = jbc_pkg::SUB_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] seqno,
  input  logic [31:0] now_us,
  input  logic [31:0] now_ms,
  output logic        done,
  output logic [2:0]  action,
  output logic [3:0]  slot,
  output logic [2:0]  sub_block,
  output logic [1:0]  mode,
  output logic [3:0]  queue_length,
  output logic [31:0] late_total,
  output logic [31:0] early_total,
  output logic [31:0] recover_ok_total,
  output logic [31:0] recover_fail_total,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jbc_pkg::*;

  localparam int PW  = $clog2(MAX_SLOTS);
  localparam int SW  = PW + 1;
  localparam int SBW = (SUB_BLOCKS > 1) ? $clog2(SUB_BLOCKS) : 1;

  cfg_t cfg;

  st_t state, state_next;

  logic [SW-1:0]  n_slots;
  logic [PW-1:0]  wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next;
  logic [SBW-1:0] sbi, sbi_next;
  mode_t          play_state, play_state_next;
  logic [31:0]    late_cnt, early_cnt, ok_cnt, fail_cnt;
  logic [31:0]    late_cnt_next, early_cnt_next, ok_cnt_next, fail_cnt_next;
  logic [31:0]    rec_start, rec_start_next;

  cmd_t           cmd_r;
  logic [31:0]    seq_r, now_us_r, now_ms_r;

  logic [31:0]    seq_a, seq_b;
  logic [PW-1:0]  ql, dlt;
  logic           is_late, is_early, cont, tmo;

  logic [PW-1:0]  nfill, nfill_next, cnt, cur, cur_next;
  logic [31:0]    fseq, fseq_next;
  act_t           fin_act, fin_act_next;
  logic [PW-1:0]  fin_slot, fin_slot_next;
  logic [SBW-1:0] fin_sb, fin_sb_next;
  logic           fin_wes, fin_wes_next, fin_wea, fin_wea_next;
  logic [31:0]    fin_wseq, fin_wseq_next;

  logic [PW-1:0]  raddr, waddr;
  logic [31:0]    rseq, rarr, wseq;
  logic           we_seq, we_arr;

  logic [31:0]    dseq, gap, since;
  logic [PW-1:0]  wr_prev;

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s, input logic [SW-1:0] n);
    wrap = (s >= n) ? PW'(s - n) : PW'(s);
  endfunction

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p, input logic [SW-1:0] n);
    nxt = wrap(SW'(p) + SW'(1), n);
  endfunction

  function automatic logic [PW-1:0] qlen(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                         input logic [SW-1:0] n);
    qlen = (w >= r) ? PW'(w - r) : PW'(SW'(w) + n - SW'(r));
  endfunction

  jbc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  jbc_slot_mem #(.DEPTH(MAX_SLOTS), .AW(PW)) u_mem (
    .clk, .rst, .raddr, .rseq, .rarr, .we_seq, .we_arr, .waddr, .wseq, .warr(now_us_r)
  );

  always_ff @(posedge clk) begin
    if (32'(cfg.slot_count) < 2) n_slots <= SW'(2);
    else if (32'(cfg.slot_count) > MAX_SLOTS) n_slots <= SW'(MAX_SLOTS);
    else n_slots <= SW'(cfg.slot_count);
  end

  assign busy    = (state != ST_IDLE);
  assign wr_prev = (wr_ptr == '0) ? PW'(n_slots - SW'(1)) : PW'(wr_ptr - PW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_NORM;
      ST_NORM: if (SW'(wr_ptr) < n_slots && SW'(rd_ptr) < n_slots) state_next = ST_RDA;
      ST_RDA:  state_next = ST_RDB;
      ST_RDB:  state_next = ST_CALC;
      ST_CALC: state_next = ST_PLAN;
      ST_PLAN: state_next = ST_EMIT;
      ST_EMIT: if (cnt == nfill) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    raddr  = (state == ST_RDA) ? rd_ptr : wr_prev;
    we_seq = 1'b0;
    we_arr = 1'b0;
    waddr  = cur;
    wseq   = fseq;
    unique case (state)
      ST_EMIT: begin
        if (cnt != nfill) begin
          we_seq = 1'b1;
          we_arr = 1'b1;
        end else begin
          we_seq = fin_wes;
          we_arr = fin_wea;
          waddr  = fin_slot;
          wseq   = fin_wseq;
        end
      end
      default: ;
    endcase
  end

  assign dseq  = seq_r - seq_a;
  assign gap   = now_us_r - rarr;
  assign since = now_ms_r - rec_start;

  // plan the item's effect
  always_comb begin
    logic [SW-1:0] s;
    logic [PW-1:0] dst;
    logic [SBW-1:0] sb_inc;
    play_state_next = play_state;
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    sbi_next        = sbi;
    late_cnt_next   = late_cnt;
    early_cnt_next  = early_cnt;
    ok_cnt_next     = ok_cnt;
    fail_cnt_next   = fail_cnt;
    rec_start_next  = rec_start;
    nfill_next      = '0;
    cur_next        = wr_ptr;
    fseq_next       = seq_b + 32'd1;
    fin_act_next    = ACT_IGNORED;
    fin_slot_next   = '0;
    fin_sb_next     = '0;
    fin_wes_next    = 1'b0;
    fin_wea_next    = 1'b0;
    fin_wseq_next   = seq_r;
    s               = '0;
    dst             = '0;
    sb_inc = (32'(sbi) == SUB_BLOCKS - 1) ? '0 : SBW'(sbi + SBW'(1));
    case (cmd_r)
      CMD_START: begin
        if (play_state == MODE_STOPPED) play_state_next = MODE_SYNCING;
      end
      CMD_STOP: begin
        if (play_state != MODE_STOPPED) begin
          play_state_next = MODE_STOPPED;
          sbi_next        = '0;
          late_cnt_next   = '0;
          early_cnt_next  = '0;
          ok_cnt_next     = '0;
          fail_cnt_next   = '0;
        end
      end
      CMD_PACKET: begin
        case (play_state)
          MODE_STOPPED: ;
          MODE_SYNCING: begin
            fin_act_next  = ACT_STORE;
            fin_slot_next = wr_ptr;
            fin_wes_next  = 1'b1;
            fin_wea_next  = 1'b1;
            if (wr_ptr != rd_ptr) begin
              if (cont) begin
                if (SW'(ql) == SW'(cfg.prefill_level)) play_state_next = MODE_PLAYING;
              end else begin
                rd_ptr_next = wr_ptr;
              end
            end
            wr_ptr_next = nxt(wr_ptr, n_slots);
          end
          default: begin
            if (is_late) begin
              late_cnt_next = late_cnt + 32'd1;
              fin_act_next  = ACT_LATE;
            end else if (is_early) begin
              early_cnt_next = early_cnt + 32'd1;
              fin_act_next   = ACT_EARLY;
            end else begin
              if (dlt >= ql) begin
                nfill_next  = PW'(dlt - ql);
                s           = SW'(wr_ptr) + SW'(nfill_next);
                dst         = wrap(s, n_slots);
                wr_ptr_next = nxt(dst, n_slots);
              end else begin
                s   = SW'(rd_ptr) + SW'(dlt);
                dst = wrap(s, n_slots);
              end
              fin_act_next  = ACT_STORE;
              fin_slot_next = dst;
              fin_wes_next  = 1'b1;
              fin_wea_next  = 1'b1;
              if (play_state == MODE_RECOVERING &&
                  SW'(qlen(wr_ptr_next, rd_ptr, n_slots)) == SW'(cfg.prefill_level)) begin
                play_state_next = MODE_PLAYING;
                ok_cnt_next     = ok_cnt + 32'd1;
              end
            end
          end
        endcase
      end
      default: begin
        case (play_state)
          MODE_PLAYING: begin
            fin_act_next  = ACT_PLAY;
            fin_slot_next = rd_ptr;
            fin_sb_next   = sbi;
            sbi_next      = sb_inc;
            if (sb_inc == '0) begin
              if (rd_ptr != wr_ptr) begin
                rd_ptr_next = nxt(rd_ptr, n_slots);
              end else begin
                play_state_next = MODE_RECOVERING;
                rec_start_next  = now_ms_r;
              end
            end
          end
          MODE_RECOVERING: begin
            fin_act_next  = ACT_SILENCE;
            fin_slot_next = rd_ptr;
            fin_sb_next   = sbi;
            sbi_next      = sb_inc;
            fin_wseq_next = seq_a + 32'd1;
            if (sb_inc == '0) begin
              if (tmo) begin
                play_state_next = MODE_SYNCING;
                fail_cnt_next   = fail_cnt + 32'd1;
              end else begin
                fin_wes_next = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      play_state <= MODE_STOPPED;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      sbi        <= '0;
      late_cnt   <= '0;
      early_cnt  <= '0;
      ok_cnt     <= '0;
      fail_cnt   <= '0;
      rec_start  <= '0;
      done       <= 1'b0;
      last       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EMIT);
      last  <= (state == ST_EMIT) && (cnt == nfill);
      unique case (state)
        ST_NORM: begin
          if (SW'(wr_ptr) >= n_slots) wr_ptr <= PW'(SW'(wr_ptr) - n_slots);
          else if (SW'(rd_ptr) >= n_slots) rd_ptr <= PW'(SW'(rd_ptr) - n_slots);
        end
        ST_PLAN: begin
          play_state <= play_state_next;
          wr_ptr     <= wr_ptr_next;
          rd_ptr     <= rd_ptr_next;
          sbi        <= sbi_next;
          late_cnt   <= late_cnt_next;
          early_cnt  <= early_cnt_next;
          ok_cnt     <= ok_cnt_next;
          fail_cnt   <= fail_cnt_next;
          rec_start  <= rec_start_next;
        end
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_r    <= cmd_t'(cmd);
      seq_r    <= seqno;
      now_us_r <= now_us;
      now_ms_r <= now_ms;
    end
    if (state == ST_RDB) seq_a <= rseq;
    if (state == ST_CALC) begin
      seq_b    <= rseq;
      ql       <= qlen(wr_ptr, rd_ptr, n_slots);
      dlt      <= PW'(dseq);
      is_late  <= (dseq == 32'd0);
      is_early <= (dseq > 32'(n_slots - SW'(1)));
      cont     <= (rseq + 32'd1 == seq_r) && (gap >= 32'(cfg.gap_lo)) &&
                  (gap <= 32'(cfg.gap_hi));
      tmo      <= (since > 32'(cfg.timeout_ms));
    end
    if (state == ST_PLAN) begin
      nfill    <= nfill_next;
      cur      <= cur_next;
      fseq     <= fseq_next;
      cnt      <= '0;
      fin_act  <= fin_act_next;
      fin_slot <= fin_slot_next;
      fin_sb   <= fin_sb_next;
      fin_wes  <= fin_wes_next;
      fin_wea  <= fin_wea_next;
      fin_wseq <= fin_wseq_next;
    end
    if (state == ST_EMIT) begin
      mode               <= play_state;
      queue_length       <= 4'(qlen(wr_ptr, rd_ptr, n_slots));
      late_total         <= late_cnt;
      early_total        <= early_cnt;
      recover_ok_total   <= ok_cnt;
      recover_fail_total <= fail_cnt;
      if (cnt != nfill) begin
        action    <= ACT_FILLER;
        slot      <= 4'(cur);
        sub_block <= 3'd0;
        cur       <= nxt(cur, n_slots);
        fseq      <= fseq + 32'd1;
        cnt       <= cnt + PW'(1);
      end else begin
        action    <= fin_act;
        slot      <= 4'(fin_slot);
        sub_block <= 3'(fin_sb);
      end
    end
  end

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && cnt == nfill) |=> (done && last && state == ST_IDLE))
    else $error("final beat did not close the item");

  a_ptrs_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDA) |-> (SW'(wr_ptr) < n_slots && SW'(rd_ptr) < n_slots))
    else $error("pointer out of range after reduction");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_NORM && !done))
    else $error("accepted command did not start the sequencer");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (SW'(nfill) < n_slots && cnt <= nfill))
    else $error("filler count beyond the ring");

endmodule
